### hw/rtl/delimiter_window_scanner_assert.svh
// ----------------------------------------------------------------------------
// delimiter window scanner assertion macros
// property wrappers clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef DELIMITER_WINDOW_SCANNER_ASSERT_SVH
`define DELIMITER_WINDOW_SCANNER_ASSERT_SVH

// condition implies consequence in the same cycle
`define DWS_ASSERT_SAME(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("same-cycle check failed");

// condition implies consequence in the next cycle
`define DWS_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### hw/rtl/dws_pkg.sv
// ----------------------------------------------------------------------------
// dws_pkg
// shared types and constants of the delimiter window scanner
// ----------------------------------------------------------------------------
package dws_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int WIN_BYTES   = 8;

    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t CFG_PATTERN = 2'd0;
    localparam cfg_index_t CFG_LENGTH  = 2'd1;
    localparam cfg_index_t CFG_MODE    = 2'd2;

    // one queued action: up to eight emitted bytes, then the outcome flags
    typedef struct packed {
        logic [8*WIN_BYTES-1:0] bytes;
        logic [3:0]             nbytes;
        logic                   found;
        logic                   done;
    } dws_entry_t;

endpackage

### hw/rtl/dws_front.sv
// ----------------------------------------------------------------------------
// dws_front
// configuration registers, sliding window and delimiter compare
// ----------------------------------------------------------------------------
module dws_front
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr,
    input  dws_pkg::cfg_index_t      cfg_index,
    input  logic [63:0]              cfg_data,
    input  logic                     accept,
    input  logic [7:0]               data_byte,
    input  logic                     end_of_stream,
    output logic                     q_wr,
    output dws_pkg::dws_entry_t      q_data
);

    localparam int WB = dws_pkg::WIN_BYTES;

    logic [63:0]     pattern_reg;
    logic [3:0]      plen_reg;
    logic            mode_reg;
    logic [8*WB-1:0] win_reg;
    logic [8*WB-1:0] win_next;
    logic [3:0]      fill_reg;
    logic [3:0]      fill_next;

    logic [3:0]      len;
    logic [3:0]      pops;
    logic [3:0]      nf0;
    logic [3:0]      nfill;
    logic [8*WB-1:0] win_sh;
    logic            match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            plen_reg    <= 4'd1;
            mode_reg    <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                dws_pkg::CFG_PATTERN: pattern_reg <= cfg_data;
                dws_pkg::CFG_LENGTH:  plen_reg    <= cfg_data[3:0];
                dws_pkg::CFG_MODE:    mode_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (plen_reg == 4'd0)
            len = 4'd1;
        else if (plen_reg > 4'(dws_pkg::MAX_PATTERN))
            len = 4'(dws_pkg::MAX_PATTERN);
        else
            len = plen_reg;
    end

    // bytes pushed out before the new one goes in
    assign pops   = (fill_reg >= len) ? (fill_reg - len + 4'd1) : 4'd0;
    assign nf0    = fill_reg - pops;
    assign nfill  = nf0 + 4'd1;
    assign win_sh = win_reg >> {pops, 3'b000};

    always_comb
    begin
        win_next = win_sh;
        match    = (nfill == len);
        for (int i = 0; i < WB; i++)
        begin
            if (nf0 == 4'(i))
                win_next[8*i +: 8] = data_byte;
        end
        for (int i = 0; i < WB; i++)
        begin
            if (4'(i) < len && win_next[8*i +: 8] != pattern_reg[8*i +: 8])
                match = 1'b0;
        end
    end

    always_comb
    begin
        q_data.bytes = win_reg;
        if (end_of_stream)
        begin
            q_data.nbytes = mode_reg ? fill_reg : 4'd0;
            q_data.found  = 1'b0;
            q_data.done   = 1'b1;
            fill_next     = 4'd0;
        end
        else
        begin
            q_data.nbytes = mode_reg ? pops : 4'd0;
            q_data.found  = match;
            q_data.done   = match;
            fill_next     = match ? 4'd0 : nfill;
        end
        q_wr = accept && (end_of_stream || match || q_data.nbytes != 4'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= 4'd0;
        else if (accept)
            fill_reg <= fill_next;
    end

    // window contents need no reset, only entries below the fill are read
    always_ff @(posedge clk)
    begin
        if (accept && !end_of_stream)
            win_reg <= win_next;
    end

endmodule

### hw/rtl/dws_queue.sv
// ----------------------------------------------------------------------------
// dws_queue
// short queue of actions between the front and the back
// ----------------------------------------------------------------------------
module dws_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  dws_pkg::dws_entry_t wr_data,
    input  logic                rd,
    output dws_pkg::dws_entry_t rd_data,
    output logic                q_full,
    output logic                q_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    dws_pkg::dws_entry_t mem_reg [DEPTH];
    logic [PW-1:0]       wr_ptr_reg;
    logic [PW-1:0]       rd_ptr_reg;
    logic [CW-1:0]       count_reg;

    assign q_full  = (count_reg == CW'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (rd)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (wr && !rd)
                count_reg <= count_reg + CW'(1);
            else if (rd && !wr)
                count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

### hw/rtl/dws_back.sv
// ----------------------------------------------------------------------------
// dws_back
// unpacks one queued action into result words, one per cycle while pop is high
// ----------------------------------------------------------------------------
module dws_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  dws_pkg::dws_entry_t q_head,
    output logic                q_rd,
    input  logic                pop,
    output logic                empty,
    output logic [7:0]          out_byte,
    output logic                byte_valid,
    output logic                found,
    output logic                done_res,
    output logic                last
);

    localparam int WB = dws_pkg::WIN_BYTES;

    logic            cur_valid_reg;
    logic [3:0]      rem_reg;
    logic [8*WB-1:0] bytes_reg;
    logic            novalid_reg;
    logic            found_reg;
    logic            done_reg;
    logic            final_word;
    logic            advance;

    assign final_word = (rem_reg == 4'd1);
    assign advance    = !cur_valid_reg || (pop && final_word);
    assign q_rd       = advance && !q_empty;

    assign empty      = !cur_valid_reg;
    assign byte_valid = !novalid_reg;
    assign out_byte   = novalid_reg ? 8'd0 : bytes_reg[7:0];
    assign found      = final_word && found_reg;
    assign done_res   = final_word && done_reg;
    assign last       = final_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            rem_reg       <= 4'd1;
        end
        else if (q_rd)
        begin
            cur_valid_reg <= 1'b1;
            rem_reg       <= (q_head.nbytes == 4'd0) ? 4'd1 : q_head.nbytes;
        end
        else if (advance)
        begin
            cur_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            rem_reg <= rem_reg - 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            bytes_reg   <= q_head.bytes;
            novalid_reg <= (q_head.nbytes == 4'd0);
            found_reg   <= q_head.found;
            done_reg    <= q_head.done;
        end
        else if (pop && cur_valid_reg)
        begin
            // next emitted byte moves to the bottom
            bytes_reg <= {8'd0, bytes_reg[8*WB-1:8]};
        end
    end

endmodule

### hw/rtl/delimiter_window_scanner.sv
// ----------------------------------------------------------------------------
// delimiter_window_scanner
// searches a byte stream for a delimiter of one to eight bytes
// ----------------------------------------------------------------------------
// Input words (data_byte, end_of_stream) are pushed with push while full is
// low. Result words (out_byte, byte_valid, found, done_res, last) are read
// with pop while empty is low; the oldest word is always on the ports.
// Configuration goes through cfg_valid/cfg_ready with cfg_index and cfg_data
// (0 pattern, 1 pattern length, 2 mode); cfg_ready is always high. The user
// must make writes while idle, which the block itself does not enforce.
// The front takes one input word per cycle while full is low, updates the
// window and compares it in the same cycle, and queues at most one action
// per word. The back turns each action, read from the queue into its own
// registers, into one to eight result words at one word per cycle while pop
// is high. Sustained rate is one input word per cycle while each word causes
// at most one result and pop stays high; a word that causes n results holds
// the back for n result words, so the queue of QUEUE_DEPTH actions absorbs
// end-of-stream flushes. A stalled pop holds the current result word; input
// continues until the queue fills, then full rises. Reset empties the window
// and the queue and restores pattern 0, length 1 and skip mode.
// ----------------------------------------------------------------------------
module delimiter_window_scanner
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          data_byte,
    input  logic                end_of_stream,
    input  logic                pop,
    output logic                empty,
    output logic [7:0]          out_byte,
    output logic                byte_valid,
    output logic                found,
    output logic                done_res,
    output logic                last,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  dws_pkg::cfg_index_t cfg_index,
    input  logic [63:0]         cfg_data
);

    logic                q_wr;
    logic                q_rd;
    logic                q_full;
    logic                q_empty;
    dws_pkg::dws_entry_t q_wr_data;
    dws_pkg::dws_entry_t q_head;
    logic                accept;

    assign cfg_ready = 1'b1;
    assign full      = q_full;
    assign accept    = push && !q_full;

    dws_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .accept        (accept),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .q_wr          (q_wr),
        .q_data        (q_wr_data)
    );

    dws_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_wr_data),
        .rd      (q_rd),
        .rd_data (q_head),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    dws_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_rd       (q_rd),
        .pop        (pop),
        .empty      (empty),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .found      (found),
        .done_res   (done_res),
        .last       (last)
    );

endmodule

### hw/rtl/dws_checker.sv
// ----------------------------------------------------------------------------
// dws_checker
// port-level checks of the delimiter window scanner, bound to the top level
// ----------------------------------------------------------------------------
`include "delimiter_window_scanner_assert.svh"

module dws_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                pop,
    input logic                empty,
    input logic [7:0]          out_byte,
    input logic                byte_valid,
    input logic                found,
    input logic                done_res,
    input logic                last
);

    // a word without a byte carries a zero byte
    `DWS_ASSERT_SAME(a_novalid_zero, !empty && !byte_valid, out_byte == 8'd0)

    // a match always closes the search and the input word
    `DWS_ASSERT_SAME(a_found_done, !empty && found, done_res && last)

    // a finished search is the last word of its input word
    `DWS_ASSERT_SAME(a_done_last, !empty && done_res, last)

    // stalled result word holds
    `DWS_ASSERT_NEXT(a_stall_hold, !empty && !pop,
        !empty && $stable(out_byte) && $stable(last) && $stable(byte_valid))

endmodule

bind delimiter_window_scanner dws_checker u_dws_checker (.*);
